[rtl/core/rhss_pkg.sv]
// shared types and constants of the substring search block
package rhss_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned FLAG_W    = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_e;

  // per-cycle control shared by all window cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[rtl/core/rolling_hash_substring_search_top.sv]
// top level of the streaming substring search: cell row, byte counter and output register
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[7:0] text_byte, tlast last_byte
//  m_axis    out  tvalid/tready         tdata[15:0] match_offset, tuser found/text_too_long
//  cfg       in   cfg_we_i (no wait)    cfg_index_i register, cfg_data_i value
//
//  one text byte per cycle unless stalled; the cells shift and compare in that cycle
//  a result is registered and shows on m_axis the cycle after its deciding byte
//  s_axis stalls only while a result is held and m_axis_tready is low
//  reset clears the window cells, the byte counter, the pattern and the length
module rolling_hash_substring_search_top #(
  parameter int unsigned     MAX_PATTERN = 16,
  parameter longint unsigned MAX_TEXT    = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rhss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rhss_pkg::REG_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rhss_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] text_byte
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rhss_pkg::OFFSET_W-1:0] m_axis_tdata,   // [15:0] match_offset
  output logic [rhss_pkg::FLAG_W-1:0]   m_axis_tuser    // [0] found, [1] text_too_long
);
  import rhss_pkg::*;

  localparam int unsigned SEEN_W = $clog2(MAX_TEXT + 64'd1);
  localparam int unsigned DIFF_W = (SEEN_W > OFFSET_W) ? SEEN_W : OFFSET_W;

  // configuration registers
  logic [LEN_W-1:0]                    len_q;
  logic [PAT_BYTES-1:0][BYTE_W-1:0]    pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LENGTH: len_q <= cfg_data_i[LEN_W-1:0];
        REG_PATTERN_LOW:    pat_q[PAT_BYTES/2-1:0] <= cfg_data_i;
        REG_PATTERN_HIGH:   pat_q[PAT_BYTES-1:PAT_BYTES/2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective pattern length
  logic [LEN_W-1:0] n_eff;
  assign n_eff = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;

  // search state
  logic [SEEN_W-1:0] seen_q, seen_d, seen_next;
  logic              done_q, done_d;
  logic              out_valid_q;
  logic              found_q, too_long_q;
  logic [OFFSET_W-1:0] offset_q;

  logic accept, zero_len, overflow, process, hit, emit;
  logic found_now, too_long_now;
  logic [DIFF_W-1:0] diff;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign zero_len      = (n_eff == '0);
  assign overflow      = (seen_q >= SEEN_W'(MAX_TEXT));
  assign process       = accept && !done_q && !zero_len && !overflow;
  assign seen_next     = seen_q + SEEN_W'(1);

  // reference byte and use mask for each cell
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] ref_bytes;
  logic [MAX_PATTERN-1:0]             in_use;
  logic [MAX_PATTERN-1:0]             eq;

  always_comb begin
    logic [LEN_W-1:0] ref_idx;
    ref_idx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      in_use[j]    = (LEN_W'(j) < n_eff);
      ref_idx      = n_eff - LEN_W'(j) - LEN_W'(1);
      ref_bytes[j] = pat_q[ref_idx[$clog2(PAT_BYTES)-1:0]];
    end
  end

  // row of window cells, newest byte in cell zero
  cell_ctrl_t                         cell_ctrl;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cell_bytes;

  assign cell_ctrl.shift = process;
  assign cell_ctrl.clear = accept && s_axis_tlast;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    if (g == 0) begin : g_head
      assign byte_in = s_axis_tdata;
    end else begin : g_link
      assign byte_in = cell_bytes[g-1];
    end
    rhss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .byte_i     (byte_in),
      .ref_byte_i (ref_bytes[g]),
      .byte_o     (cell_bytes[g]),
      .eq_o       (eq[g])
    );
  end

  // match once the window holds at least a pattern's worth of bytes
  assign hit = (&(eq | ~in_use)) && (seen_next >= SEEN_W'(n_eff));

  assign emit         = accept && !done_q && (zero_len || overflow || hit || s_axis_tlast);
  assign found_now    = zero_len || (!overflow && hit);
  assign too_long_now = !zero_len && overflow;
  assign diff         = DIFF_W'(seen_next) - DIFF_W'(n_eff);

  // next counter and done flag
  always_comb begin
    seen_d = seen_q;
    done_d = done_q;
    if (accept && s_axis_tlast) begin
      seen_d = '0;
      done_d = 1'b0;
    end else begin
      if (process) begin
        seen_d = seen_next;
      end
      if (emit) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      done_q <= done_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q    <= found_now;
      too_long_q <= too_long_now;
      offset_q   <= (found_now && !zero_len) ? diff[OFFSET_W-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = offset_q;
  assign m_axis_tuser  = {too_long_q, found_q};

  // checks
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and text_too_long both set");

  a_miss_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("offset not zero without a match");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SEEN_W'(MAX_TEXT))
    else $error("byte counter beyond text range");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (seen_q == '0 && !done_q))
    else $error("search not re-armed after last byte");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !s_axis_tlast) |=> done_q)
    else $error("search not closed after a result");

endmodule

[rtl/core/rhss_cell.sv]
// one window cell: holds a text byte, passes it on and compares the incoming byte
module rhss_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rhss_pkg::cell_ctrl_t       ctrl_i,
  input  logic [rhss_pkg::BYTE_W-1:0] byte_i,
  input  logic [rhss_pkg::BYTE_W-1:0] ref_byte_i,
  output logic [rhss_pkg::BYTE_W-1:0] byte_o,
  output logic                       eq_o
);
  import rhss_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;

  // shift in the neighbour's byte, clear at end of text
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare the byte this cell takes on the next shift
  assign eq_o   = (byte_i == ref_byte_i);
  assign byte_o = byte_q;

endmodule
